>>> design/mlae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MADT local APIC enumerator package
// Shared constants and types for the front end, the command queue and the
// back end of the enumerator.
// ----------------------------------------------------------------------------
package mlae_pkg;

    localparam int MAX_CPUS = 16;
    localparam int CNT_W    = $clog2(MAX_CPUS + 1);
    localparam int IDX_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    // Byte offsets inside one MADT entry.
    localparam logic [7:0] OFF_TYPE    = 8'd0;
    localparam logic [7:0] OFF_LENGTH  = 8'd1;
    localparam logic [7:0] OFF_ACPI_ID = 8'd2;
    localparam logic [7:0] OFF_APIC_ID = 8'd3;
    localparam logic [7:0] OFF_FLAGS   = 8'd4;

    localparam logic [7:0] TYPE_LOCAL_APIC = 8'd0;
    localparam logic [7:0] MIN_ENTRY_LEN   = 8'd2;
    localparam logic [7:0] LAPIC_ENTRY_LEN = 8'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // APB register map
    localparam int              APB_ADDR_W    = 3;
    localparam logic            REG_BOOT_APIC = 1'b0;

    // One classified byte handed from the front end to the back end.
    typedef struct packed {
        logic       start;      // table restarts with this byte
        logic       candidate;  // byte completed an enabled local APIC entry
        logic       halted;     // parsing is stopped after this byte
        logic [7:0] apic_id;
        logic [7:0] acpi_id;
    } mlae_cmd_t;

    typedef struct packed {
        logic       parse_stopped;
        logic [7:0] added_acpi_id;
        logic [7:0] added_apic_id;
        logic       cpu_added;
        logic [4:0] cpu_total;
    } mlae_result_t;

endpackage
`default_nettype wire

>>> design/madt_local_apic_enumerator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MADT local APIC enumerator
// Walks the MADT entry area one byte per transaction and builds the list of
// enabled processors, one result per byte.
// ----------------------------------------------------------------------------
// The block takes one byte of the MADT entry area per clock unless stalled and
// returns one result per byte, in order. A result passes through the queue and
// the back end's result register before it appears on the master side; with
// both sides free the block sustains one byte per cycle. That rate is set by
// the combinational framing step in the front end and the combinational
// parallel duplicate compare over the processor table in the back end, with a
// two-entry queue between them so either side can stall without losing a byte.
// Mark the first byte of a table with s_axis_tuser to clear the table and seed
// the boot processor, and the last byte with s_axis_tlast. Write the boot
// processor's APIC id at address 0 only while the block is idle.
module madt_local_apic_enumerator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] start_of_table
    input  wire logic        s_axis_tlast,   // end_of_table
    // Results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] cpu_total, [5] cpu_added, [13:6] added_apic_id,
    // [21:14] added_acpi_id, [22] parse_stopped, [23] zero
    output logic [23:0]      m_axis_tdata
);
    import mlae_pkg::*;

    logic [7:0]   boot_apic_reg;
    logic         byte_take;
    logic         can_push;
    logic         pop;
    logic         head_valid;
    mlae_cmd_t    front_cmd;
    mlae_cmd_t    head_cmd;
    mlae_result_t result;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_apic_reg <= 8'd0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1] == REG_BOOT_APIC)) begin
            boot_apic_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        if (paddr[APB_ADDR_W-1] == REG_BOOT_APIC) begin
            prdata = {24'd0, boot_apic_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    assign s_axis_tready = can_push;
    assign byte_take     = s_axis_tvalid && can_push;

    mlae_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_take      (byte_take),
        .data_byte      (s_axis_tdata),
        .start_of_table (s_axis_tuser),
        .end_of_table   (s_axis_tlast),
        .cmd            (front_cmd)
    );

    mlae_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (byte_take),
        .push_cmd   (front_cmd),
        .can_push   (can_push),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    mlae_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .boot_apic_id (boot_apic_reg),
        .head_cmd     (head_cmd),
        .head_valid   (head_valid),
        .pop          (pop),
        .result       (result),
        .result_valid (m_axis_tvalid),
        .result_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule
`default_nettype wire

>>> design/mlae_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MADT enumerator front end
// Frames entries by their type and length bytes and classifies every byte
// into a command for the back end.
// ----------------------------------------------------------------------------
module mlae_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               byte_take,
    input  wire logic [7:0]         data_byte,
    input  wire logic               start_of_table,
    input  wire logic               end_of_table,
    output mlae_pkg::mlae_cmd_t     cmd
);
    import mlae_pkg::*;

    logic [7:0] offset_reg, offset_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] acpi_reg, acpi_next;
    logic [7:0] apic_reg, apic_next;
    logic       enabled_reg, enabled_next;
    logic       halted_reg, halted_next;

    logic [7:0] offset_cur;
    logic       halted_cur;
    logic       complete;

    always_comb begin
        offset_cur   = start_of_table ? 8'd0 : offset_reg;
        halted_cur   = start_of_table ? 1'b0 : halted_reg;
        type_next    = start_of_table ? 8'd0 : type_reg;
        length_next  = start_of_table ? 8'd0 : length_reg;
        acpi_next    = start_of_table ? 8'd0 : acpi_reg;
        apic_next    = start_of_table ? 8'd0 : apic_reg;
        enabled_next = start_of_table ? 1'b0 : enabled_reg;
        halted_next  = halted_cur;
        offset_next  = offset_cur;
        complete     = 1'b0;

        if (!halted_cur) begin
            case (offset_cur)
                OFF_TYPE: begin
                    type_next = data_byte;
                end
                OFF_LENGTH: begin
                    length_next = data_byte;
                    if (data_byte < MIN_ENTRY_LEN) begin
                        halted_next = 1'b1;
                    end
                end
                OFF_ACPI_ID: begin
                    acpi_next = data_byte;
                end
                OFF_APIC_ID: begin
                    apic_next = data_byte;
                end
                OFF_FLAGS: begin
                    enabled_next = data_byte[0];
                end
                default: begin
                end
            endcase

            // The last byte of an entry is the one at offset length - 1.
            complete = !halted_next && (offset_cur != OFF_TYPE) &&
                       (({1'b0, offset_cur} + 9'd1) >= {1'b0, length_next});

            if (halted_next || complete || end_of_table) begin
                offset_next = 8'd0;
            end else begin
                offset_next = offset_cur + 8'd1;
            end
        end

        cmd.start     = start_of_table;
        cmd.candidate = complete && (type_next == TYPE_LOCAL_APIC) &&
                        (length_next >= LAPIC_ENTRY_LEN) && enabled_next;
        cmd.halted    = halted_next;
        cmd.apic_id   = apic_next;
        cmd.acpi_id   = acpi_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= 8'd0;
            type_reg    <= 8'd0;
            length_reg  <= 8'd0;
            acpi_reg    <= 8'd0;
            apic_reg    <= 8'd0;
            enabled_reg <= 1'b0;
            halted_reg  <= 1'b0;
        end else if (byte_take) begin
            offset_reg  <= offset_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            acpi_reg    <= acpi_next;
            apic_reg    <= apic_next;
            enabled_reg <= enabled_next;
            halted_reg  <= halted_next;
        end
    end

endmodule
`default_nettype wire

>>> design/mlae_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MADT enumerator command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module mlae_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire mlae_pkg::mlae_cmd_t push_cmd,
    output logic                    can_push,
    input  wire logic               pop,
    output mlae_pkg::mlae_cmd_t     head_cmd,
    output logic                    head_valid
);
    import mlae_pkg::*;

    mlae_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign can_push   = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> design/mlae_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MADT enumerator back end
// Keeps the processor table, checks for duplicate APIC ids, adds processors
// and holds the result register.
// ----------------------------------------------------------------------------
module mlae_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         boot_apic_id,
    input  wire mlae_pkg::mlae_cmd_t head_cmd,
    input  wire logic               head_valid,
    output logic                    pop,
    output mlae_pkg::mlae_result_t  result,
    output logic                    result_valid,
    input  wire logic               result_ready
);
    import mlae_pkg::*;

    logic [7:0]       apic_table_reg [MAX_CPUS];
    logic [CNT_W-1:0] count_reg, count_next;
    mlae_result_t     result_reg, result_next;
    logic             valid_reg;
    logic             duplicate;
    logic             add;

    assign pop          = head_valid && (!valid_reg || result_ready);
    assign result       = result_reg;
    assign result_valid = valid_reg;

    // Parallel compare against every occupied table slot.
    always_comb begin
        duplicate = 1'b0;
        for (int j = 0; j < MAX_CPUS; j++) begin
            if ((CNT_W'(j) < count_reg) && (apic_table_reg[j] == head_cmd.apic_id)) begin
                duplicate = 1'b1;
            end
        end
    end

    always_comb begin
        add = head_cmd.candidate && !head_cmd.start && !duplicate &&
              (count_reg < CNT_W'(MAX_CPUS));
        if (head_cmd.start) begin
            count_next = CNT_W'(1);
        end else if (add) begin
            count_next = count_reg + CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
        result_next.cpu_total     = 5'(count_next);
        result_next.cpu_added     = add;
        result_next.added_apic_id = add ? head_cmd.apic_id : 8'd0;
        result_next.added_acpi_id = add ? head_cmd.acpi_id : 8'd0;
        result_next.parse_stopped = head_cmd.halted;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
            if (head_cmd.start) begin
                apic_table_reg[0] <= boot_apic_id;
            end else if (add) begin
                apic_table_reg[count_reg[IDX_W-1:0]] <= head_cmd.apic_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(1);
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end else if (result_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/sv/apic_enum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local APIC enumeration checker
// Watches the byte stream, the result stream and the APB port of the MADT
// local APIC enumerator. It keeps its own copy of the entry framing and the
// processor table and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module apic_enum_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] start_of_table
    input  wire logic        s_axis_tlast,   // end_of_table
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] cpu_total, [5] cpu_added, [13:6] added_apic_id,
    // [21:14] added_acpi_id, [22] parse_stopped, [23] zero
    input  wire logic [23:0] m_axis_tdata,
    output int               mismatch_count,
    output int               pending_results
);
    import mlae_pkg::*;

    localparam logic [2:0] BOOT_APIC_ADDR = {REG_BOOT_APIC, 2'b00};

    logic [7:0]   boot_apic;
    logic [7:0]   apic_tbl [MAX_CPUS];
    int unsigned  cpu_cnt;
    logic [7:0]   offset;
    logic [7:0]   ent_type;
    logic [7:0]   ent_len;
    logic [7:0]   pend_acpi;
    logic [7:0]   pend_apic;
    logic         pend_en;
    logic         halted;

    mlae_result_t expected_enum [$];
    int           fail_total = 0;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    function automatic void clear_parse();
        cpu_cnt   = 1;
        offset    = OFF_TYPE;
        ent_type  = '0;
        ent_len   = '0;
        pend_acpi = '0;
        pend_apic = '0;
        pend_en   = 1'b0;
        halted    = 1'b0;
    endfunction

    // Advances the framing by one byte and returns the result it produces.
    function automatic mlae_result_t step_enum(input logic [7:0] b, input logic st,
                                               input logic la);
        mlae_result_t r;
        logic         done;
        logic         dup;
        int           j;
        r    = '0;
        done = 1'b0;
        dup  = 1'b0;
        if (st) begin
            clear_parse();
            apic_tbl[0] = boot_apic;
        end
        if (!halted) begin
            case (offset)
                OFF_TYPE:    ent_type = b;
                OFF_LENGTH: begin
                    ent_len = b;
                    if (b < MIN_ENTRY_LEN) halted = 1'b1;
                end
                OFF_ACPI_ID: pend_acpi = b;
                OFF_APIC_ID: pend_apic = b;
                OFF_FLAGS:   pend_en = b[0];
                default: ;
            endcase
            if (!halted && offset >= OFF_LENGTH && {1'b0, offset} + 9'd1 >= {1'b0, ent_len})
                done = 1'b1;
            if (halted) begin
                offset = OFF_TYPE;
            end else if (done) begin
                for (j = 0; j < MAX_CPUS; j++) begin
                    if (j < cpu_cnt && apic_tbl[j] == pend_apic) dup = 1'b1;
                end
                if (ent_type == TYPE_LOCAL_APIC && ent_len >= LAPIC_ENTRY_LEN && pend_en &&
                    !dup && cpu_cnt < MAX_CPUS) begin
                    apic_tbl[cpu_cnt] = pend_apic;
                    cpu_cnt           = cpu_cnt + 1;
                    r.cpu_added       = 1'b1;
                    r.added_apic_id   = pend_apic;
                    r.added_acpi_id   = pend_acpi;
                end
                offset = OFF_TYPE;
            end else if (la) begin
                offset = OFF_TYPE;
            end else begin
                offset = offset + 8'd1;
            end
        end
        r.cpu_total     = 5'(cpu_cnt);
        r.parse_stopped = halted;
        return r;
    endfunction

    always @(posedge aclk) begin
        mlae_result_t want;
        mlae_result_t got;
        if (!aresetn) begin
            boot_apic = '0;
            clear_parse();
            expected_enum.delete();
        end else begin
            // Results are retired before this edge's byte is predicted, so a
            // spurious result can never be matched against a fresh prediction.
            if (m_axis_tvalid && m_axis_tready) begin
                got = mlae_result_t'(m_axis_tdata[22:0]);
                if (expected_enum.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result %h arrived with no byte pending",
                                 $realtime, m_axis_tdata);
                    fail_total++;
                end else begin
                    want = expected_enum.pop_front();
                    if (got.cpu_total !== want.cpu_total || got.cpu_added !== want.cpu_added ||
                        got.added_apic_id !== want.added_apic_id ||
                        got.added_acpi_id !== want.added_acpi_id ||
                        got.parse_stopped !== want.parse_stopped || m_axis_tdata[23] !== 1'b0) begin
                        if (fail_total < 10)
                            $display({"%0t: mismatch: expected total=%0d added=%b apic=%h ",
                                      "acpi=%h stopped=%b, got total=%0d added=%b apic=%h ",
                                      "acpi=%h stopped=%b pad=%b"},
                                     $realtime, want.cpu_total, want.cpu_added,
                                     want.added_apic_id, want.added_acpi_id, want.parse_stopped,
                                     got.cpu_total, got.cpu_added, got.added_apic_id,
                                     got.added_acpi_id, got.parse_stopped, m_axis_tdata[23]);
                        fail_total++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == BOOT_APIC_ADDR)
                boot_apic = pwdata[7:0];
            if (s_axis_tvalid && s_axis_tready)
                expected_enum.push_back(step_enum(s_axis_tdata, s_axis_tuser, s_axis_tlast));
        end
        pending_results <= expected_enum.size();
        mismatch_count  <= fail_total;
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MADT local APIC enumerator testbench
// Streams directed and random MADT entry areas into the enumerator with
// random gaps and back-pressure, rewrites the boot APIC id between tables,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
    import mlae_pkg::*;

    localparam logic [2:0] BOOT_APIC_ADDR = {REG_BOOT_APIC, 2'b00};
    localparam int         TARGET_BYTES   = 2000;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       last;
    } madt_byte_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int          mismatch_count;
    int          pending_results;

    madt_byte_t  madt_bytes [$];
    int          bytes_sent    = 0;
    bit          sender_steady = 1'b0;
    int          stall_left    = 0;
    int          steady_left   = 0;

    madt_local_apic_enumerator_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    apic_enum_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("madt_local_apic_enumerator_unit verification failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (steady_left > 0) begin
            steady_left--;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            steady_left = $urandom_range(20, 120);
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void push_byte(input logic [7:0] d, input logic st, input logic la);
        madt_byte_t b;
        b.data  = d;
        b.start = st;
        b.last  = la;
        madt_bytes.push_back(b);
    endfunction

    function automatic void push_lapic(input logic [7:0] acpi, input logic [7:0] apic,
                                       input logic [7:0] flags, input int len);
        push_byte(TYPE_LOCAL_APIC, 1'b0, 1'b0);
        push_byte(8'(len), 1'b0, 1'b0);
        push_byte(acpi, 1'b0, 1'b0);
        push_byte(apic, 1'b0, 1'b0);
        push_byte(flags, 1'b0, 1'b0);
        for (int k = 5; k < len; k++) push_byte(8'($urandom), 1'b0, 1'b0);
    endfunction

    function automatic void push_skipped(input logic [7:0] kind, input int len);
        push_byte(kind, 1'b0, 1'b0);
        push_byte(8'(len), 1'b0, 1'b0);
        for (int k = 2; k < len; k++) push_byte(8'($urandom), 1'b0, 1'b0);
    endfunction

    // Builds one entry area: mostly well-formed processor entries, with
    // skipped entries, bad lengths, cut-off entries and noise mixed in.
    function automatic void build_random_madt();
        int         entries;
        bit         wide_ids;
        int         r;
        int         first;
        logic [7:0] flags;
        wide_ids = ($urandom_range(0, 3) == 0);
        entries  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
        for (int e = 0; e < entries; e++) begin
            r     = $urandom_range(0, 99);
            first = madt_bytes.size();
            flags = 8'($urandom);
            if ($urandom_range(0, 4) != 0) flags[0] = 1'b1;
            if (r < 60) begin
                push_lapic(8'($urandom), wide_ids ? 8'($urandom) : 8'($urandom_range(0, 23)),
                           flags, ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : 8);
            end else if (r < 72) begin
                push_skipped(TYPE_LOCAL_APIC, $urandom_range(2, 7));
            end else if (r < 86) begin
                push_skipped(8'($urandom_range(1, 255)), $urandom_range(2, 12));
            end else if (r < 90) begin
                push_byte(8'($urandom_range(0, 3)), 1'b0, 1'b0);
                push_byte(8'($urandom_range(0, 1)), 1'b0, 1'b0);
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom), 1'b0, 1'b0);
            end else if (r < 96) begin
                push_lapic(8'($urandom), 8'($urandom_range(0, 23)), flags, 8);
                madt_bytes[first + $urandom_range(0, 6)].last = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0, 1'b0);
            end
        end
        madt_bytes[0].start = 1'b1;
        // Now and then the next start arrives in the middle of an entry.
        if ($urandom_range(0, 9) != 0) madt_bytes[$].last = 1'b1;
    endfunction

    task automatic send_byte(input madt_byte_t b);
        int gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 3) == 0) gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b.data;
        s_axis_tuser  <= b.start;
        s_axis_tlast  <= b.last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_madt();
        sender_steady = ($urandom_range(0, 3) == 0);
        foreach (madt_bytes[k]) send_byte(madt_bytes[k]);
        madt_bytes.delete();
    endtask

    // The checker's count is registered, so wait_idle lets the last accepted
    // byte show up in it before the count is trusted.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic apb_write_boot(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BOOT_APIC_ADDR;
        pwdata  <= {24'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [7:0] boot;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        apb_write_boot(8'h00);

        // Directed: extreme ids added, duplicate of the boot processor,
        // another entry type, a bad length that halts, a start that carries
        // the end with only a type byte, and a disabled entry ending the table.
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        repeat (3) push_byte(8'h00, 1'b0, 1'b0);
        push_lapic(8'h07, 8'h00, 8'h01, 8);
        push_skipped(8'hFF, 2);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        push_lapic(8'h03, 8'h03, 8'hFE, 8);
        madt_bytes[$].last = 1'b1;
        send_madt();

        wait_idle();
        apb_write_boot(8'hFF);
        while (bytes_sent < TARGET_BYTES) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0:       boot = 8'h00;
                    1:       boot = 8'hFF;
                    2:       boot = 8'($urandom_range(0, 23));
                    default: boot = 8'($urandom);
                endcase
                wait_idle();
                apb_write_boot(boot);
            end
            build_random_madt();
            send_madt();
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("madt_local_apic_enumerator_unit verification clean");
        end else begin
            $display("madt_local_apic_enumerator_unit verification failed");
        end
        $finish;
    end

endmodule
